@@ src/rtp_header_parser_defines.svh @@
// Assertion macros used by the RTP header parser top level.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef RTP_HEADER_PARSER_DEFINES_SVH
`define RTP_HEADER_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define RTPH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define RTPH_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define RTPH_ASSERT(label, prop, msg)
`define RTPH_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ src/rtph_pkg.sv @@
// Types and constants for the RTP header parser.
// No dependencies; used by rtph_core and rtp_header_parser.
package rtph_pkg;

    typedef struct packed {
        logic [7:0] pkt_byte;
        logic       pkt_last;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic        last_of_run;
        logic [3:0]  status;
        logic [7:0]  marker_and_type;
        logic [15:0] seq_number;
        logic [31:0] time_stamp;
        logic [31:0] sync_source;
        logic [3:0]  contrib_count;
        logic [15:0] ext_tag;
        logic [15:0] item_offset;
        logic [15:0] item_length;
        logic [7:0]  pad_count;
    } t_out_item;

    // Results of one byte: an optional element record and an optional summary
    typedef struct packed {
        logic      elem_valid;
        logic      sum_valid;
        t_out_item elem;
        t_out_item summ;
    } t_push;

    typedef enum logic [1:0] {
        PH_HDR  = 2'd0,
        PH_LEN  = 2'd1,
        PH_SKIP = 2'd2,
        PH_STOP = 2'd3
    } t_phase;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_NOT_RTP     = 4'd1;
    localparam logic [3:0] ST_CSRC_SHORT  = 4'd2;
    localparam logic [3:0] ST_EXT_HDR     = 4'd3;
    localparam logic [3:0] ST_EXT_VALUE   = 4'd4;
    localparam logic [3:0] ST_PAD_NO_PAY  = 4'd5;
    localparam logic [3:0] ST_PAD_ZERO    = 4'd6;
    localparam logic [3:0] ST_PAD_BIG     = 4'd7;
    localparam logic [3:0] ST_OVERSIZE    = 4'd8;

    localparam logic       KIND_ELEM      = 1'b0;
    localparam logic       KIND_SUMMARY   = 1'b1;

    localparam logic [15:0] PROF_ONE_BYTE = 16'hBEDE;
    localparam logic [11:0] PROF_TWO_BYTE = 12'h100;
    localparam logic [3:0]  ID_STOP       = 4'hF;
    localparam logic [1:0]  RTP_VERSION   = 2'd2;

endpackage

@@ src/rtp_header_parser.sv @@
// RTP header parser top level: byte-wide input, parse core, result queue.
// Depends on rtph_pkg, rtph_core and rtp_header_parser_defines.svh.
//
// Usage:
//   Input channel (i_valid / o_ready / i_data) carries one packet byte per
//   item, pkt_last set on the final byte. Output channel (o_valid / i_ready /
//   o_data) carries result items: one record per extension element that fits
//   in its region, plus a packet summary on the final byte.
// Ordering: each result is queued when its byte is taken and reaches o_data after earlier results.
// Throughput: one byte per cycle while o_ready is high. A byte can cause two results (an element
//   and the summary), and the output side drains one per cycle, so a run of
//   such bytes is paced by the 4-entry result queue.
// Backpressure: o_ready stays high while the queue has room for two results;
//   a stalled receiver fills the queue and then holds off new bytes. Queued
//   results are never dropped or reordered.
// Reset: i_rst_n (synchronous, active low) clears packet state and empties
//   the queue; the next byte taken is byte 0 of a new packet. Packet state
//   also clears after every final byte.
`include "rtp_header_parser_defines.svh"
module rtp_header_parser #(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rtph_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output rtph_pkg::t_out_item o_data
);

    rtph_pkg::t_push     push;
    rtph_pkg::t_out_item r_q [4];
    logic [1:0]          r_wp, r_rp;
    logic [2:0]          r_cnt, n_cnt;
    logic                take, pop;
    logic [1:0]          n_pushes;

    assign o_ready = (r_cnt <= 3'd2);
    assign take    = i_valid && o_ready;
    assign o_valid = (r_cnt != 3'd0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_q[r_rp];

    rtph_core #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_data),
        .o_push  (push)
    );

    assign n_pushes = 2'(push.elem_valid) + 2'(push.sum_valid);
    assign n_cnt    = r_cnt + 3'(n_pushes) - 3'(pop);

    // Element goes first when both results come from one byte
    always_ff @(posedge i_clk) begin
        if (push.elem_valid) r_q[r_wp] <= push.elem;
        if (push.sum_valid) begin
            if (push.elem_valid) r_q[r_wp + 2'd1] <= push.summ;
            else                 r_q[r_wp]        <= push.summ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + n_pushes;
            r_rp  <= r_rp + 2'(pop);
            r_cnt <= n_cnt;
        end
    end

    `RTPH_ASSERT(a_cnt_bound, r_cnt <= 3'd4, "result queue overflow")
    `RTPH_ASSERT(a_last_gives_result, take && i_data.pkt_last |=> o_valid,
                 "final byte produced no summary")
    `RTPH_ASSERT(a_no_take_full, !o_ready |-> r_cnt >= 3'd3, "input stalled with queue room")
    `RTPH_ASSERT(a_cnt_track, !$past(pop) && $past(take) && $past(i_data.pkt_last)
                 |-> r_cnt > $past(r_cnt), "summary not queued")
    `RTPH_ASSERT_ALWAYS(a_reset_empty, !$past(i_rst_n) |-> r_cnt == 3'd0,
                        "queue not empty after reset")

endmodule

@@ src/rtph_core.sv @@
// Per-byte packet state and result formation for the RTP header parser.
// Depends on rtph_pkg.
module rtph_core #(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  rtph_pkg::t_in_item i_item,
    output rtph_pkg::t_push   o_push
);

    localparam logic [16:0] MAXB = 17'(MAX_PACKET_BYTES);

    logic [16:0] r_idx, n_idx;
    logic [7:0]  r_first, n_first;
    logic [7:0]  r_second, n_second;
    logic [15:0] r_seq, n_seq;
    logic [31:0] r_ts, n_ts;
    logic [31:0] r_ssrc, n_ssrc;
    logic [15:0] r_prof, n_prof;
    logic [16:0] r_eend, n_eend;
    logic [16:0] r_pstart, n_pstart;
    rtph_pkg::t_phase r_phase, n_phase;
    logic [8:0]  r_skip, n_skip;
    logic [7:0]  r_eid, n_eid;
    logic [7:0]  r_prev, n_prev;
    logic [3:0]  r_err, n_err;

    logic [7:0]  b;
    logic [16:0] hs;
    logic [17:0] i_p1;
    logic [18:0] e_full;
    logic        one, two;
    logic        emit;
    logic [15:0] e_id;
    logic [8:0]  e_len;
    logic [17:0] len;
    logic [3:0]  st;
    logic [16:0] plen;
    logic [7:0]  pad;

    always_comb begin
        b        = i_item.pkt_byte;
        n_idx    = r_idx;
        n_first  = r_first;
        n_second = r_second;
        n_seq    = r_seq;
        n_ts     = r_ts;
        n_ssrc   = r_ssrc;
        n_prof   = r_prof;
        n_eend   = r_eend;
        n_pstart = r_pstart;
        n_phase  = r_phase;
        n_skip   = r_skip;
        n_eid    = r_eid;
        n_prev   = r_prev;
        n_err    = r_err;
        emit     = 1'b0;
        e_id     = '0;
        e_len    = '0;
        hs       = 17'd12 + {11'd0, r_first[3:0], 2'b00};
        i_p1     = {1'b0, r_idx} + 18'd1;
        // 19 bits: header size plus the largest word count does not fit in 18
        e_full   = {2'b00, hs} + 19'd4 + {1'b0, r_prev, b, 2'b00};
        one      = (r_prof == rtph_pkg::PROF_ONE_BYTE);
        two      = (r_prof[15:4] == rtph_pkg::PROF_TWO_BYTE);

        if (r_idx >= MAXB) begin
            n_err = rtph_pkg::ST_OVERSIZE;
        end else if (r_idx == 17'd0) begin
            n_first = b;
            if (b[7:6] != rtph_pkg::RTP_VERSION) n_err = rtph_pkg::ST_NOT_RTP;
            n_pstart = 17'd12 + {11'd0, b[3:0], 2'b00};
            n_eend   = 17'd12 + {11'd0, b[3:0], 2'b00};
        end else if (r_idx == 17'd1) begin
            n_second = b;
        end else if (r_idx < 17'd4) begin
            n_seq = {r_seq[7:0], b};
        end else if (r_idx < 17'd8) begin
            n_ts = {r_ts[23:0], b};
        end else if (r_idx < 17'd12) begin
            n_ssrc = {r_ssrc[23:0], b};
        end else if (r_first[4]) begin
            if (r_idx == hs || r_idx == hs + 17'd2) begin
                n_prev = b;
            end else if (r_idx == hs + 17'd1) begin
                n_prof = {r_prev, b};
            end else if (r_idx == hs + 17'd3) begin
                n_eend   = (e_full[18:17] != 2'b00) ? 17'h1FFFF : e_full[16:0];
                n_pstart = (e_full[18:17] != 2'b00) ? 17'h1FFFF : e_full[16:0];
            end else if (r_idx > hs + 17'd3 && r_idx < r_eend
                         && r_err == rtph_pkg::ST_OK && (one || two)) begin
                unique case (r_phase)
                    rtph_pkg::PH_HDR: begin
                        if (b != 8'd0) begin
                            if (one) begin
                                if (b[7:4] == rtph_pkg::ID_STOP) begin
                                    n_phase = rtph_pkg::PH_STOP;
                                end else if (i_p1 + 18'(b[3:0]) + 18'd1
                                             > {1'b0, r_eend}) begin
                                    n_phase = rtph_pkg::PH_STOP;
                                end else begin
                                    emit    = 1'b1;
                                    e_id    = {12'd0, b[7:4]};
                                    e_len   = 9'(b[3:0]) + 9'd1;
                                    n_skip  = 9'(b[3:0]) + 9'd1;
                                    n_phase = rtph_pkg::PH_SKIP;
                                end
                            end else begin
                                n_eid   = b;
                                n_phase = rtph_pkg::PH_LEN;
                            end
                        end
                    end
                    rtph_pkg::PH_LEN: begin
                        if (i_p1 + 18'(b) > {1'b0, r_eend}) begin
                            n_phase = rtph_pkg::PH_STOP;
                        end else begin
                            emit    = 1'b1;
                            e_id    = {8'd0, r_eid};
                            e_len   = {1'b0, b};
                            n_skip  = {1'b0, b};
                            n_phase = (b == 8'd0) ? rtph_pkg::PH_HDR : rtph_pkg::PH_SKIP;
                        end
                    end
                    rtph_pkg::PH_SKIP: begin
                        n_skip = r_skip - 9'd1;
                        if (r_skip == 9'd1) n_phase = rtph_pkg::PH_HDR;
                    end
                    rtph_pkg::PH_STOP: begin
                        n_phase = r_phase;
                    end
                    default: n_phase = r_phase;
                endcase
            end
        end
        if (r_idx <= MAXB) n_idx = r_idx + 17'd1;
    end

    // Packet summary, built from the state after this byte
    always_comb begin
        len  = i_p1;
        st   = n_err;
        plen = '0;
        pad  = '0;
        if (st == rtph_pkg::ST_OK) begin
            priority if (len < 18'd12) st = rtph_pkg::ST_NOT_RTP;
            else if (len < {1'b0, hs}) st = rtph_pkg::ST_CSRC_SHORT;
            else if (n_first[4] && len < {1'b0, hs} + 18'd4) st = rtph_pkg::ST_EXT_HDR;
            else if (n_first[4] && len < {1'b0, n_eend}) st = rtph_pkg::ST_EXT_VALUE;
            else st = rtph_pkg::ST_OK;
        end
        if (st == rtph_pkg::ST_OK) begin
            plen = len[16:0] - n_pstart;
            if (n_first[5]) begin
                priority if (plen == 17'd0) st = rtph_pkg::ST_PAD_NO_PAY;
                else if (b == 8'd0) st = rtph_pkg::ST_PAD_ZERO;
                else if (plen < 17'(b)) st = rtph_pkg::ST_PAD_BIG;
                else begin
                    pad  = b;
                    plen = plen - 17'(b);
                end
            end
        end
        if (st != rtph_pkg::ST_OK) begin
            plen = '0;
            pad  = '0;
        end
    end

    always_comb begin
        o_push.elem_valid           = i_take && emit;
        o_push.sum_valid            = i_take && i_item.pkt_last;
        o_push.elem.kind            = rtph_pkg::KIND_ELEM;
        o_push.elem.last_of_run     = !i_item.pkt_last;
        o_push.elem.status          = rtph_pkg::ST_OK;
        o_push.elem.marker_and_type = n_second;
        o_push.elem.seq_number      = n_seq;
        o_push.elem.time_stamp      = n_ts;
        o_push.elem.sync_source     = n_ssrc;
        o_push.elem.contrib_count   = n_first[3:0];
        o_push.elem.ext_tag         = e_id;
        o_push.elem.item_offset     = i_p1[15:0];
        o_push.elem.item_length     = {7'd0, e_len};
        o_push.elem.pad_count       = '0;
        o_push.summ                 = o_push.elem;
        o_push.summ.kind            = rtph_pkg::KIND_SUMMARY;
        o_push.summ.last_of_run     = 1'b1;
        o_push.summ.status          = st;
        o_push.summ.ext_tag         = n_prof;
        o_push.summ.item_offset     = (st == rtph_pkg::ST_OK) ? n_pstart[15:0] : 16'd0;
        o_push.summ.item_length     = plen[15:0];
        o_push.summ.pad_count       = pad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_item.pkt_last)) begin
            r_idx    <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_seq    <= '0;
            r_ts     <= '0;
            r_ssrc   <= '0;
            r_prof   <= '0;
            r_eend   <= '0;
            r_pstart <= '0;
            r_phase  <= rtph_pkg::PH_HDR;
            r_skip   <= '0;
            r_eid    <= '0;
            r_prev   <= '0;
            r_err    <= rtph_pkg::ST_OK;
        end else if (i_take) begin
            r_idx    <= n_idx;
            r_first  <= n_first;
            r_second <= n_second;
            r_seq    <= n_seq;
            r_ts     <= n_ts;
            r_ssrc   <= n_ssrc;
            r_prof   <= n_prof;
            r_eend   <= n_eend;
            r_pstart <= n_pstart;
            r_phase  <= n_phase;
            r_skip   <= n_skip;
            r_eid    <= n_eid;
            r_prev   <= n_prev;
            r_err    <= n_err;
        end
    end

endmodule
